@@ rtl/ioreb_pkg.sv @@
// Package for the in-order event reorder buffer.
// Holds the result status codes, fixed field widths and the control/status
// structs shared by the controller and the datapath. No dependencies.
package ioreb_pkg;

  localparam int SEQ_W       = 32;
  localparam int OUT_PAY_W   = 16;
  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  typedef enum logic [2:0] {
    ST_RELEASED  = 3'd0,
    ST_BUFFERED  = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_STALE     = 3'd3,
    ST_BEYOND    = 3'd4
  } status_t;

  typedef struct packed {
    logic capture;
    logic eval_commit;
    logic rel_read;
    logic rel_commit;
  } cmd_t;

  typedef struct packed {
    logic own_result;
    logic own_last;
    logic rel_last;
    logic out_free;
  } sts_t;

endpackage

@@ rtl/ioreb_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; used for the slot payload store of the reorder buffer.
module ioreb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/ioreb_ctrl.sv @@
// Controller state machine of the reorder buffer.
// Sequences capture, evaluation and the release loop; uses ioreb_pkg.
module ioreb_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  ioreb_pkg::sts_t sts,
  output ioreb_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_EVAL  = 4'b0010,
    S_RREAD = 4'b0100,
    S_ROUT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
        if (in_tvalid) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (!sts.own_result) begin
          cmd.eval_commit = 1'b1;
          state_nxt       = S_RREAD;
        end else if (sts.out_free) begin
          cmd.eval_commit = 1'b1;
          state_nxt       = sts.own_last ? S_IDLE : S_RREAD;
        end
      end
      S_RREAD: begin
        cmd.rel_read = 1'b1;
        state_nxt    = S_ROUT;
      end
      S_ROUT: begin
        if (sts.out_free) begin
          cmd.rel_commit = 1'b1;
          state_nxt      = sts.rel_last ? S_IDLE : S_RREAD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ rtl/ioreb_dp.sv @@
// Datapath of the reorder buffer: expected counter, window head, valid bits,
// payload RAM and output register. Uses ioreb_pkg and ioreb_ram.
module ioreb_dp #(
  parameter int WINDOW       = 16,
  parameter int PAYLOAD_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ioreb_pkg::cmd_t                 cmd,
  output ioreb_pkg::sts_t                 sts,
  input  logic [ioreb_pkg::SEQ_W-1:0]     in_seq,
  input  logic [ioreb_pkg::OUT_PAY_W-1:0] in_pay,
  input  logic                            cfg_wr,
  input  logic [ioreb_pkg::SEQ_W-1:0]     cfg_data,
  input  logic                            out_tready,
  output logic                            out_valid,
  output ioreb_pkg::status_t              out_status,
  output logic [ioreb_pkg::SEQ_W-1:0]     out_seq,
  output logic [ioreb_pkg::OUT_PAY_W-1:0] out_pay,
  output logic                            out_last
);

  localparam int IW   = $clog2(WINDOW);
  localparam int PW_X = ioreb_pkg::OUT_PAY_W + PAYLOAD_BITS;

  logic [ioreb_pkg::SEQ_W-1:0]     seq_r;
  logic [ioreb_pkg::OUT_PAY_W-1:0] pay_r;
  logic [ioreb_pkg::SEQ_W-1:0]     next_exp_r;
  logic [IW-1:0]                   head_r;
  logic [WINDOW-1:0]               valid_r, valid_nxt;
  logic [ioreb_pkg::CNT_W-1:0]     count_r;

  logic                            out_valid_r;
  ioreb_pkg::status_t              out_status_r;
  logic [ioreb_pkg::SEQ_W-1:0]     out_seq_r;
  logic [ioreb_pkg::OUT_PAY_W-1:0] out_pay_r;
  logic                            out_last_r;

  logic [ioreb_pkg::SEQ_W-1:0] off;
  logic                        is_stale, is_beyond, is_dup, is_buf;
  ioreb_pkg::status_t          own_status;
  logic [IW:0]                 idx_sum;
  logic [IW-1:0]               idx;
  logic [IW-1:0]               head_inc;
  logic [PW_X-1:0]             pay_in_x;
  logic [PW_X-1:0]             pay_out_x;
  logic [PAYLOAD_BITS-1:0]     ram_rdata;
  logic                        out_free;

  assign off       = seq_r - next_exp_r;
  assign is_stale  = seq_r < next_exp_r;
  assign is_beyond = !is_stale && (off >= ioreb_pkg::SEQ_W'(WINDOW));
  assign idx_sum   = {1'b0, head_r} + {1'b0, off[IW-1:0]};
  assign idx       = (idx_sum >= (IW+1)'(WINDOW)) ? IW'(idx_sum - (IW+1)'(WINDOW))
                                                  : idx_sum[IW-1:0];
  assign is_dup    = !is_stale && !is_beyond && valid_r[idx];
  assign is_buf    = !is_stale && !is_beyond && !valid_r[idx];
  assign head_inc  = (head_r == IW'(WINDOW - 1)) ? '0 : head_r + IW'(1);

  always_comb begin
    priority if (is_stale) begin
      own_status = ioreb_pkg::ST_STALE;
    end else if (is_beyond) begin
      own_status = ioreb_pkg::ST_BEYOND;
    end else if (is_dup) begin
      own_status = ioreb_pkg::ST_DUPLICATE;
    end else begin
      own_status = ioreb_pkg::ST_BUFFERED;
    end
  end

  assign out_free       = !out_valid_r || out_tready;
  assign sts.out_free   = out_free;
  assign sts.own_result = !(is_buf && (off == '0));
  assign sts.own_last   = !valid_r[head_r];
  assign sts.rel_last   = !valid_r[head_inc] ||
                          (count_r == ioreb_pkg::CNT_W'(ioreb_pkg::MAX_RESULTS - 1));

  assign pay_in_x  = PW_X'(pay_r);
  assign pay_out_x = PW_X'(ram_rdata);

  ioreb_ram #(
    .WIDTH(PAYLOAD_BITS),
    .DEPTH(WINDOW)
  ) u_ram (
    .clk  (clk),
    .we   (cmd.eval_commit && is_buf),
    .waddr(idx),
    .wdata(pay_in_x[PAYLOAD_BITS-1:0]),
    .re   (cmd.rel_read),
    .raddr(head_r),
    .rdata(ram_rdata)
  );

  always_comb begin
    valid_nxt = valid_r;
    if (cfg_wr) begin
      valid_nxt = '0;
    end else if (cmd.eval_commit && is_buf) begin
      valid_nxt[idx] = 1'b1;
    end else if (cmd.rel_commit) begin
      valid_nxt[head_r] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      seq_r <= in_seq;
      pay_r <= in_pay;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_exp_r <= ioreb_pkg::SEQ_W'(1);
      head_r     <= '0;
      valid_r    <= '0;
      count_r    <= '0;
    end else begin
      valid_r <= valid_nxt;
      if (cfg_wr) begin
        next_exp_r <= cfg_data;
        head_r     <= '0;
      end else if (cmd.rel_commit) begin
        next_exp_r <= next_exp_r + ioreb_pkg::SEQ_W'(1);
        head_r     <= head_inc;
        count_r    <= count_r + ioreb_pkg::CNT_W'(1);
      end else if (cmd.eval_commit) begin
        count_r <= sts.own_result ? ioreb_pkg::CNT_W'(1) : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.rel_commit || (cmd.eval_commit && sts.own_result)) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rel_commit) begin
      out_status_r <= ioreb_pkg::ST_RELEASED;
      out_seq_r    <= next_exp_r;
      out_pay_r    <= pay_out_x[ioreb_pkg::OUT_PAY_W-1:0];
      out_last_r   <= sts.rel_last;
    end else if (cmd.eval_commit && sts.own_result) begin
      out_status_r <= own_status;
      out_seq_r    <= '0;
      out_pay_r    <= '0;
      out_last_r   <= sts.own_last;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_seq    = out_seq_r;
  assign out_pay    = out_pay_r;
  assign out_last   = out_last_r;

endmodule

@@ rtl/in_order_event_reorder_buffer.sv @@
// Top level: releases sequence-numbered events strictly in order.
// An item's own status result is loaded into the output register in the evaluation step
// after the item is captured; each release reads the payload RAM, then loads the output register.
// A new item is taken only once the last one and all its releases are done; an output stall holds both.
// Synchronous active-low reset clears the window valid bits, sets the expected
// number to one and the window head to slot zero; no clearing pass is needed.
module in_order_event_reorder_buffer #(
  parameter int WINDOW       = 16,
  parameter int PAYLOAD_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [31:0] sequence_number, [47:32] payload_handle
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [31:0] released_sequence, [47:32] released_payload
  output logic [2:0]  out_tuser,  // [2:0] status
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  ioreb_pkg::cmd_t    cmd;
  ioreb_pkg::sts_t    sts;
  ioreb_pkg::status_t out_status;

  assign cfg_ready = 1'b1;

  ioreb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ioreb_dp #(
    .WINDOW      (WINDOW),
    .PAYLOAD_BITS(PAYLOAD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_seq    (in_tdata[31:0]),
    .in_pay    (in_tdata[47:32]),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .out_tready(out_tready),
    .out_valid (out_tvalid),
    .out_status(out_status),
    .out_seq   (out_tdata[31:0]),
    .out_pay   (out_tdata[47:32]),
    .out_last  (out_tlast)
  );

  assign out_tuser = out_status;

endmodule

@@ rtl/ioreb_checker.sv @@
// Port-level checker for the reorder buffer, bound to the top level.
// Uses ioreb_pkg for the status codes.
module ioreb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("Stalled result transfer changed.");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser <= 3'(ioreb_pkg::ST_BEYOND))
    else $error("Result status out of range.");

  a_own_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != 3'(ioreb_pkg::ST_RELEASED) |-> out_tdata == '0)
    else $error("Non-release result carries data.");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("Second item taken while one is being evaluated.");

endmodule

bind in_order_event_reorder_buffer ioreb_checker u_ioreb_checker (.*);

@@ test/event_order_checker.sv @@
// Checker for the in-order event reorder buffer: watches the event, result and
// start-number channels, predicts every result and compares it field by field.
// Depends on ioreb_pkg for the status codes and field widths.
`timescale 1ns / 1ps

module event_order_checker #(
  parameter int WINDOW = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,   // [31:0] sequence_number, [47:32] payload_handle
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,  // [31:0] released_sequence, [47:32] released_payload
  input  logic [2:0]  out_tuser,  // [2:0] status
  input  logic        out_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [31:0] cfg_data,
  output int          mismatches,
  output int          pending,
  output int          n_events,
  output int          n_results
);

  typedef struct packed {
    ioreb_pkg::status_t              status;
    logic [ioreb_pkg::SEQ_W-1:0]     seq;
    logic [ioreb_pkg::OUT_PAY_W-1:0] pay;
    logic                            last;
  } order_result_t;

  order_result_t                   expected_results[$];
  logic [ioreb_pkg::SEQ_W-1:0]     next_seq;
  logic [WINDOW-1:0]               slot_held;
  logic [ioreb_pkg::OUT_PAY_W-1:0] slot_pay [WINDOW];
  int                              head;
  int                              errs = 0;
  int                              events_seen = 0;
  int                              results_seen = 0;

  function automatic void clear_window(input logic [ioreb_pkg::SEQ_W-1:0] start);
    next_seq  = start;
    slot_held = '0;
    head      = 0;
  endfunction

  function automatic void add_expected(input order_result_t r);
    expected_results.insert(expected_results.size(), r);
  endfunction

  function automatic order_result_t take_expected();
    order_result_t r;
    r = expected_results[0];
    expected_results.delete(0);
    return r;
  endfunction

  function automatic void predict_event(input logic [ioreb_pkg::SEQ_W-1:0] seq,
                                        input logic [ioreb_pkg::OUT_PAY_W-1:0] pay);
    logic [ioreb_pkg::SEQ_W-1:0] off;
    int                          idx;
    ioreb_pkg::status_t          st;
    order_result_t               batch [ioreb_pkg::MAX_RESULTS];
    int                          n;
    n   = 0;
    off = seq - next_seq;
    if (seq < next_seq) begin
      st = ioreb_pkg::ST_STALE;
    end else if (off >= WINDOW) begin
      st = ioreb_pkg::ST_BEYOND;
    end else begin
      idx = (head + int'(off)) % WINDOW;
      if (slot_held[idx]) begin
        st = ioreb_pkg::ST_DUPLICATE;
      end else begin
        slot_held[idx] = 1'b1;
        slot_pay[idx]  = pay;
        st = ioreb_pkg::ST_BUFFERED;
      end
    end
    if (!(st == ioreb_pkg::ST_BUFFERED && off == 0)) begin
      batch[n] = '{st, '0, '0, 1'b0};
      n++;
    end
    while (n < ioreb_pkg::MAX_RESULTS && slot_held[head]) begin
      batch[n] = '{ioreb_pkg::ST_RELEASED, next_seq, slot_pay[head], 1'b0};
      n++;
      slot_held[head] = 1'b0;
      next_seq = next_seq + 32'd1;
      head = (head + 1) % WINDOW;
    end
    batch[n - 1].last = 1'b1;
    for (int i = 0; i < n; i++) begin
      add_expected(batch[i]);
    end
  endfunction

  function automatic void note_failure(input string msg);
    errs++;
    if (errs <= 10) begin
      $display("%s", msg);
    end
  endfunction

  always @(posedge clk) begin : watch
    order_result_t got;
    order_result_t want;
    if (!rst_n) begin
      clear_window(32'd1);
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        clear_window(cfg_data);
      end
      if (in_tvalid && in_tready) begin
        predict_event(in_tdata[31:0], in_tdata[47:32]);
        events_seen++;
      end
      if (out_tvalid && out_tready) begin
        got.status = ioreb_pkg::status_t'(out_tuser);
        got.seq    = out_tdata[31:0];
        got.pay    = out_tdata[47:32];
        got.last   = out_tlast;
        results_seen++;
        if (expected_results.size() == 0) begin
          note_failure($sformatf(
            "Unexpected result transfer: status %0d seq %h pay %h last %0d",
            got.status, got.seq, got.pay, got.last));
        end else begin
          want = take_expected();
          if (got != want) begin
            note_failure($sformatf(
              "Result %0d wrong: expected status %0d seq %h pay %h last %0d, got %0d %h %h %0d",
              results_seen, want.status, want.seq, want.pay, want.last,
              got.status, got.seq, got.pay, got.last));
          end
        end
      end
    end
    mismatches <= errs;
    pending    <= expected_results.size();
    n_events   <= events_seen;
    n_results  <= results_seen;
  end

endmodule

@@ test/in_order_event_reorder_buffer_tb.sv @@
// Testbench top for the in-order event reorder buffer: drives reset, start
// numbers and event streams under several idling patterns, and gives the verdict.
// Depends on ioreb_pkg, the block itself and event_order_checker.
`timescale 1ns / 1ps

module in_order_event_reorder_buffer_tb;

  localparam int WINDOW      = 16;
  localparam int CYCLE_LIMIT = 200000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;

  int idle_pct = 0;
  int stall_pct = 0;
  int cycles = 0;
  int settings_used = 1;
  int mismatches;
  int pending;
  int n_events;
  int n_results;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  in_order_event_reorder_buffer #(
    .WINDOW(WINDOW),
    .PAYLOAD_BITS(16)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .out_tlast(out_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  event_order_checker #(
    .WINDOW(WINDOW)
  ) u_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .out_tlast(out_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .mismatches(mismatches),
    .pending(pending),
    .n_events(n_events),
    .n_results(n_results)
  );

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_event(input logic [31:0] seq, input logic [15:0] pay);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {pay, seq};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic write_start(input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Mostly shuffled runs of consecutive numbers, with repeats, stale,
  // out-of-window and fully random numbers mixed in.
  task automatic run_random(input logic [31:0] base, input int n_items, input bit hold_mid);
    logic [31:0] order [WINDOW];
    logic [31:0] tmp;
    int          k;
    int          j;
    int          r;
    int          sent;
    bit          held;
    sent = 0;
    held = 1'b0;
    while (sent < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        k = $urandom_range(1, WINDOW);
        for (int i = 0; i < k; i++) order[i] = base + i;
        for (int i = k - 1; i > 0; i--) begin
          j = $urandom_range(0, i);
          tmp = order[i];
          order[i] = order[j];
          order[j] = tmp;
        end
        for (int i = 0; i < k; i++) begin
          send_event(order[i], 16'($urandom_range(0, 16'hFFFF)));
          sent++;
          if ($urandom_range(0, 9) == 0) begin
            send_event(order[$urandom_range(0, i)], 16'($urandom_range(0, 16'hFFFF)));
            sent++;
          end
        end
        base = base + k;
      end else begin
        if (r < 85) begin
          send_event(base - $urandom_range(1, 40), 16'($urandom_range(0, 16'hFFFF)));
        end else if (r < 93) begin
          send_event(base + WINDOW + $urandom_range(0, 3),
                     16'($urandom_range(0, 16'hFFFF)));
        end else begin
          send_event($urandom, 16'($urandom_range(0, 16'hFFFF)));
        end
        sent++;
      end
      if (hold_mid && !held && sent >= n_items / 2) begin
        wait_idle();
        held = 1'b1;
      end
    end
  endtask

  initial begin
    logic [31:0] starts [5];
    int          idles  [5];
    int          stalls [5];
    starts = '{32'h0000_0000, 32'hFFFF_FFF4, $urandom, 32'hFFFF_FFFF, 32'h7FFF_FFF8};
    idles  = '{0, 49, 0, 24, 24};
    stalls = '{0, 0, 49, 24, 24};
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    out_tready <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_data   <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part from the reset start number of one.
    send_event(32'd1, 16'hFFFF);
    send_event(32'd3, 16'h0000);
    send_event(32'd3, 16'h1234);
    send_event(32'd0, 16'hFFFF);
    send_event(32'd18, 16'($urandom_range(0, 16'hFFFF)));
    send_event(32'd2, 16'($urandom_range(0, 16'hFFFF)));
    send_event(32'hFFFF_FFFF, 16'($urandom_range(0, 16'hFFFF)));
    send_event(32'd19, 16'($urandom_range(0, 16'hFFFF)));
    send_event(32'd20, 16'($urandom_range(0, 16'hFFFF)));
    for (int s = 5; s <= 18; s++) send_event(s, 16'($urandom_range(0, 16'hFFFF)));
    send_event(32'd4, 16'($urandom_range(0, 16'hFFFF)));
    wait_idle();

    for (int p = 0; p < 5; p++) begin
      idle_pct  = 0;
      stall_pct = 0;
      write_start(starts[p]);
      idle_pct  = idles[p];
      stall_pct = stalls[p];
      run_random(starts[p], 31, p == 2);
      wait_idle();
    end

    $display("Run covered %0d event transfers and %0d result transfers under %0d start numbers,",
             n_events, n_results, settings_used);
    $display("including sequence wrap-around, full releases and idling on either side.");
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
